FILE: hdl/lls_pkg.sv
// ----------------------------------------------------------------------------
// lls_pkg
// Shared types and timing constants for the LCD line/mode sequencer.
// ----------------------------------------------------------------------------
package lls_pkg;

  // Line and frame timing
  localparam int unsigned DOTS_PER_LINE  = 456;
  localparam int unsigned VISIBLE_LINES  = 144;
  localparam int unsigned TOTAL_LINES    = 154;
  localparam int unsigned VISIBLE_WIDTH  = 160;
  localparam int unsigned SCAN_DOTS      = 80;
  localparam int unsigned SCAN_START_DOT = 1;
  localparam int unsigned WIN_X_LIMIT    = 166;

  localparam int unsigned DOT_W   = 9;
  localparam int unsigned LINE_W  = 8;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned FRAME_W = 16;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LYC_VALUE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAT_ENABLES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X      = 3'd4;

  // STAT enable bits
  localparam int unsigned STAT_HBLANK_BIT = 0;
  localparam int unsigned STAT_VBLANK_BIT = 1;
  localparam int unsigned STAT_LYC_BIT    = 2;

  // Mode codes as seen on the result port
  localparam logic [MODE_W-1:0] CODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] CODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] CODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] CODE_XFER   = 2'd3;

  typedef struct packed {
    logic [LINE_W-1:0] lyc_value;
    logic [2:0]        stat_enables;
    logic              window_enable;
    logic [LINE_W-1:0] window_y;
    logic [LINE_W-1:0] window_x;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LINE_W-1:0]  line_number;
    logic               coincidence;
    logic [LINE_W-1:0]  window_row;
    logic               stat_irq;
    logic               vblank_irq;
    logic               scan_start;
    logic               xfer_start;
    logic               xfer_end;
    logic [FRAME_W-1:0] frame_number;
  } res_t;

endpackage

FILE: hdl/lls_timing.sv
// ----------------------------------------------------------------------------
// lls_timing
// Dot, line, window-line and frame counters with the PPU mode state machine.
// One dot tick is processed per cycle in which step is high.
// ----------------------------------------------------------------------------
module lls_timing (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [lls_pkg::PIX_W-1:0]   pushed,
  input  lls_pkg::cfg_t               cfg,
  output lls_pkg::res_t               res
);
  import lls_pkg::*;

  typedef enum logic [3:0] {
    ST_HBLANK = 4'b0001,
    ST_VBLANK = 4'b0010,
    ST_OAM    = 4'b0100,
    ST_XFER   = 4'b1000
  } state_t;

  state_t              mode_r, mode_nxt;
  logic [DOT_W-1:0]    dot_r, dot_nxt, dot_inc;
  logic [LINE_W-1:0]   line_r, line_nxt, adv_line;
  logic [LINE_W-1:0]   win_r, win_nxt;
  logic                lyc_r, lyc_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic                line_end, win_on, win_hit, lyc_hit;
  logic                stat, vbl, scan, xs, xe;
  logic [MODE_W-1:0]   mode_code;

  always_comb begin
    dot_inc  = dot_r + DOT_W'(1);
    line_end = dot_inc >= DOT_W'(DOTS_PER_LINE);
    adv_line = line_r + LINE_W'(1);
    win_on   = cfg.window_enable && (cfg.window_x <= LINE_W'(WIN_X_LIMIT)) &&
               ({1'b0, cfg.window_y} < 9'(VISIBLE_LINES));
    win_hit  = win_on && (line_r >= cfg.window_y) &&
               ({1'b0, line_r} < ({1'b0, cfg.window_y} + 9'(VISIBLE_LINES)));
    lyc_hit  = adv_line == cfg.lyc_value;
  end

  always_comb begin
    mode_nxt  = mode_r;
    dot_nxt   = dot_inc;
    line_nxt  = line_r;
    win_nxt   = win_r;
    lyc_nxt   = lyc_r;
    frame_nxt = frame_r;
    stat      = 1'b0;
    vbl       = 1'b0;
    scan      = 1'b0;
    xs        = 1'b0;
    xe        = 1'b0;
    unique case (mode_r)
      ST_OAM: begin
        if (dot_inc >= DOT_W'(SCAN_DOTS)) begin
          mode_nxt = ST_XFER;
          xs       = 1'b1;
        end
        scan = dot_inc == DOT_W'(SCAN_START_DOT);
      end
      ST_XFER: begin
        if (pushed >= PIX_W'(VISIBLE_WIDTH)) begin
          mode_nxt = ST_HBLANK;
          xe       = 1'b1;
          stat     = cfg.stat_enables[STAT_HBLANK_BIT];
        end
      end
      ST_HBLANK: begin
        if (line_end) begin
          line_nxt = adv_line;
          win_nxt  = win_hit ? win_r + LINE_W'(1) : win_r;
          lyc_nxt  = lyc_hit;
          stat     = lyc_hit && cfg.stat_enables[STAT_LYC_BIT];
          dot_nxt  = '0;
          if ({1'b0, adv_line} >= 9'(VISIBLE_LINES)) begin
            mode_nxt  = ST_VBLANK;
            vbl       = 1'b1;
            stat      = stat | cfg.stat_enables[STAT_VBLANK_BIT];
            frame_nxt = frame_r + FRAME_W'(1);
          end else begin
            mode_nxt = ST_OAM;
          end
        end
      end
      ST_VBLANK: begin
        if (line_end) begin
          line_nxt = adv_line;
          win_nxt  = win_hit ? win_r + LINE_W'(1) : win_r;
          lyc_nxt  = lyc_hit;
          stat     = lyc_hit && cfg.stat_enables[STAT_LYC_BIT];
          dot_nxt  = '0;
          // past the last line: wrap LY and window line, LYC flag from the compare with the unwrapped line
          if ({1'b0, adv_line} >= 9'(TOTAL_LINES)) begin
            mode_nxt = ST_OAM;
            line_nxt = '0;
            win_nxt  = '0;
          end
        end
      end
      default: mode_nxt = ST_OAM;
    endcase
  end

  always_comb begin
    unique case (mode_nxt)
      ST_HBLANK: mode_code = CODE_HBLANK;
      ST_VBLANK: mode_code = CODE_VBLANK;
      ST_OAM:    mode_code = CODE_OAM;
      ST_XFER:   mode_code = CODE_XFER;
      default:   mode_code = CODE_OAM;
    endcase
  end

  always_comb begin
    res.mode         = mode_code;
    res.line_number  = line_nxt;
    res.coincidence  = lyc_nxt;
    res.window_row   = win_nxt;
    res.stat_irq     = stat;
    res.vblank_irq   = vbl;
    res.scan_start   = scan;
    res.xfer_start   = xs;
    res.xfer_end     = xe;
    res.frame_number = frame_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ST_OAM;
      dot_r   <= '0;
      line_r  <= '0;
      win_r   <= '0;
      lyc_r   <= 1'b0;
      frame_r <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      dot_r   <= dot_nxt;
      line_r  <= line_nxt;
      win_r   <= win_nxt;
      lyc_r   <= lyc_nxt;
      frame_r <= frame_nxt;
    end
  end

`ifndef SYNTH
  a_vblank_enters: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.vblank_irq |=> mode_r == ST_VBLANK)
    else $error("vblank irq without entering vblank");
  a_xfer_end_hblank: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.xfer_end |=> mode_r == ST_HBLANK)
    else $error("transfer end without entering hblank");
  a_line_dot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && (line_nxt != line_r) |=> dot_r == '0)
    else $error("line changed but dot counter not cleared");
  a_frame_only_vbl: assert property (@(posedge clk) disable iff (!rst_n)
    step && !res.vblank_irq |=> $stable(frame_r))
    else $error("frame counter moved outside vblank entry");
`endif

endmodule

FILE: hdl/lls_out_reg.sv
// ----------------------------------------------------------------------------
// lls_out_reg
// Result register with valid/stall handshake towards the receiver.
// ----------------------------------------------------------------------------
module lls_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  lls_pkg::res_t res_in,
  input  logic          out_stall,
  output logic          free,
  output logic          out_valid,
  output lls_pkg::res_t res_out
);
  import lls_pkg::*;

  logic valid_r;
  res_t res_r;

  // room when empty or the held beat leaves this cycle
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

FILE: hdl/lcd_line_mode_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_line_mode_sequencer
// PPU mode timing: OAM scan, transfer, HBLANK and VBLANK sequencing per dot.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one beat per dot tick (in_pushed_pixels, the count
//   of pixels pushed so far on the line). Each input beat yields exactly one
//   result beat: mode, LY, LYC flag, window line, interrupt and pulse flags
//   and the frame count, all as they stand after that dot.
//   A beat accepted into the input register is processed by the timing step
//   once the result register has room, and shown on the out_ ports from there.
//   Throughput: one beat per cycle unless the result side stalls; input and
//   result registers form a two-stage pipe, counters updating on each step.
//   A stall on the result side holds the result register; in_stall rises
//   only once the input register is also full.
//   Configuration (cfg_we/cfg_index/cfg_wdata) is to be written while idle;
//   the block does not enforce this. Indexes beyond the register list are ignored.
//   Reset (rst_n low, synchronous) empties both stages, clears all config
//   registers and counters and starts the sequencer in OAM scan on line 0.
// ----------------------------------------------------------------------------
module lcd_line_mode_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lls_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lls_pkg::PIX_W-1:0]         in_pushed_pixels,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lls_pkg::MODE_W-1:0]        out_mode,
  output logic [lls_pkg::LINE_W-1:0]        out_line_number,
  output logic                              out_coincidence,
  output logic [lls_pkg::LINE_W-1:0]        out_window_row,
  output logic                              out_stat_irq,
  output logic                              out_vblank_irq,
  output logic                              out_scan_start,
  output logic                              out_xfer_start,
  output logic                              out_xfer_end,
  output logic [lls_pkg::FRAME_W-1:0]       out_frame_number
);
  import lls_pkg::*;

  cfg_t              cfg_r;
  logic              in_valid_r;
  logic [PIX_W-1:0]  pushed_r;
  logic              out_free;
  logic              step;
  res_t              res_step;
  res_t              res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LYC_VALUE:     cfg_r.lyc_value     <= cfg_wdata;
        REG_STAT_ENABLES:  cfg_r.stat_enables  <= cfg_wdata[2:0];
        REG_WINDOW_ENABLE: cfg_r.window_enable <= cfg_wdata[0];
        REG_WINDOW_Y:      cfg_r.window_y      <= cfg_wdata;
        REG_WINDOW_X:      cfg_r.window_x      <= cfg_wdata;
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      pushed_r <= in_pushed_pixels;
    end
  end

  lls_timing u_timing (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .pushed (pushed_r),
    .cfg    (cfg_r),
    .res    (res_step)
  );

  lls_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_in    (res_step),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign out_mode         = res_out.mode;
  assign out_line_number  = res_out.line_number;
  assign out_coincidence  = res_out.coincidence;
  assign out_window_row   = res_out.window_row;
  assign out_stat_irq     = res_out.stat_irq;
  assign out_vblank_irq   = res_out.vblank_irq;
  assign out_scan_start   = res_out.scan_start;
  assign out_xfer_start   = res_out.xfer_start;
  assign out_xfer_end     = res_out.xfer_end;
  assign out_frame_number = res_out.frame_number;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LCD line/mode sequencer. Each input beat is one
// dot; the bench keeps its own model of the mode, LY, window line, LYC flag
// and frame count and checks every result beat field by field. A short table
// of dots straight after reset is followed by a few lines of dots, split
// into phases with a fresh register setting each, with random gaps on both
// channels, one long result stall and one stretch without gaps.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lls_pkg::*;

  localparam int          RESET_CYCLES = 6;
  localparam int          IDLE_PCT     = 13;
  localparam int          N_PHASES     = 8;
  localparam int          PHASE_DOTS   = 200;    // under half a line per phase
  localparam int          STEADY_PHASE = 2;
  localparam int          HOLD_PHASE   = 5;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  typedef enum logic [1:0] {PIX_RAMP, PIX_NOISE, PIX_STUCK} pix_style_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             typed;   // expected result written out below
    logic             scan;
  } dir_row_t;

  // Dots 1..20 of line 0 after reset: all in OAM scan, pixel count ignored
  localparam dir_row_t DIRECTED [0:19] = '{
    '{8'h00, 1'b1, 1'b1}, '{8'hFF, 1'b1, 1'b0}, '{8'h55, 1'b0, 1'b0},
    '{8'hAA, 1'b0, 1'b0}, '{8'hA0, 1'b0, 1'b0}, '{8'h9F, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0}, '{8'h80, 1'b0, 1'b0}, '{8'h7F, 1'b0, 1'b0},
    '{8'hFE, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0}, '{8'hFF, 1'b1, 1'b0},
    '{8'h0F, 1'b0, 1'b0}, '{8'hF0, 1'b0, 1'b0}, '{8'h33, 1'b0, 1'b0},
    '{8'hCC, 1'b0, 1'b0}, '{8'h10, 1'b0, 1'b0}, '{8'hEF, 1'b0, 1'b0},
    '{8'h40, 1'b0, 1'b0}, '{8'hBF, 1'b0, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pushed_pixels = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [MODE_W-1:0]     out_mode;
  logic [LINE_W-1:0]     out_line_number;
  logic                  out_coincidence;
  logic [LINE_W-1:0]     out_window_row;
  logic                  out_stat_irq;
  logic                  out_vblank_irq;
  logic                  out_scan_start;
  logic                  out_xfer_start;
  logic                  out_xfer_end;
  logic [FRAME_W-1:0]    out_frame_number;

  lcd_line_mode_sequencer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pushed_pixels (in_pushed_pixels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mode         (out_mode),
    .out_line_number  (out_line_number),
    .out_coincidence  (out_coincidence),
    .out_window_row   (out_window_row),
    .out_stat_irq     (out_stat_irq),
    .out_vblank_irq   (out_vblank_irq),
    .out_scan_start   (out_scan_start),
    .out_xfer_start   (out_xfer_start),
    .out_xfer_end     (out_xfer_end),
    .out_frame_number (out_frame_number)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sequencer model state and register shadow
  cfg_t               cfg_sh    = '0;
  logic [MODE_W-1:0]  st_mode   = CODE_OAM;
  logic [LINE_W-1:0]  st_ly     = '0;
  logic [DOT_W-1:0]   st_dot    = '0;
  logic [LINE_W-1:0]  st_win    = '0;
  logic               st_lyc    = 1'b0;
  logic [FRAME_W-1:0] st_frames = '0;

  res_t pending_dots [$];
  int   bad_fields = 0;

  // Pixel pipeline imitation
  pix_style_t px_style   = PIX_RAMP;
  int         px_ramp    = 0;
  int         stuck_left = 0;

  bit          steady     = 1'b0;
  int          hold_req   = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  int unsigned cycles     = 0;

  // Line end: LY, window line and LYC flag; returns the LYC STAT source
  function logic bump_line();
    logic win_on;
    win_on = cfg_sh.window_enable && cfg_sh.window_x <= WIN_X_LIMIT &&
             cfg_sh.window_y < VISIBLE_LINES;
    if (win_on && st_ly >= cfg_sh.window_y &&
        int'(st_ly) < int'(cfg_sh.window_y) + int'(VISIBLE_LINES)) begin
      st_win = st_win + 8'd1;
    end
    st_ly  = st_ly + 8'd1;
    st_lyc = (st_ly == cfg_sh.lyc_value);
    return st_lyc && cfg_sh.stat_enables[STAT_LYC_BIT];
  endfunction

  function res_t advance_dot(input logic [PIX_W-1:0] pix);
    res_t r;
    r = '0;
    st_dot = st_dot + 9'd1;
    case (st_mode)
      CODE_OAM: begin
        if (st_dot >= SCAN_DOTS) begin
          st_mode      = CODE_XFER;
          r.xfer_start = 1'b1;
        end
        if (st_dot == SCAN_START_DOT) r.scan_start = 1'b1;
      end
      CODE_XFER: begin
        if (pix >= VISIBLE_WIDTH) begin
          r.xfer_end = 1'b1;
          st_mode    = CODE_HBLANK;
          r.stat_irq = cfg_sh.stat_enables[STAT_HBLANK_BIT];
        end
      end
      CODE_HBLANK: begin
        if (st_dot >= DOTS_PER_LINE) begin
          r.stat_irq = bump_line();
          if (st_ly >= VISIBLE_LINES) begin
            st_mode      = CODE_VBLANK;
            r.vblank_irq = 1'b1;
            if (cfg_sh.stat_enables[STAT_VBLANK_BIT]) r.stat_irq = 1'b1;
            st_frames    = st_frames + 16'd1;
          end else begin
            st_mode = CODE_OAM;
          end
          st_dot = '0;
        end
      end
      default: begin
        if (st_dot >= DOTS_PER_LINE) begin
          r.stat_irq = bump_line();
          if (st_ly >= TOTAL_LINES) begin
            st_mode = CODE_OAM;
            st_ly   = '0;
            st_win  = '0;
          end
          st_dot = '0;
        end
      end
    endcase
    r.mode         = st_mode;
    r.line_number  = st_ly;
    r.coincidence  = st_lyc;
    r.window_row   = st_win;
    r.frame_number = st_frames;
    return r;
  endfunction

  // Mostly a rising pixel count during transfer, sometimes noise or a
  // pipeline stuck below the visible width before finishing (dot counter may wrap)
  function logic [PIX_W-1:0] next_pixels();
    if (st_mode != CODE_XFER) return PIX_W'($urandom_range(0, 255));
    case (px_style)
      PIX_NOISE: return PIX_W'($urandom_range(0, 255));
      PIX_STUCK: begin
        if (stuck_left > 0) begin
          stuck_left--;
          return PIX_W'($urandom_range(0, VISIBLE_WIDTH - 1));
        end
        return PIX_W'($urandom_range(VISIBLE_WIDTH, 255));
      end
      default: begin
        if ($urandom_range(0, 3) != 0 && px_ramp < 255) px_ramp++;
        return PIX_W'(px_ramp);
      end
    endcase
  endfunction

  task automatic push_dot(input logic [PIX_W-1:0] pix, input logic typed,
                          input res_t want);
    res_t got;
    int   roll;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_pushed_pixels <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = advance_dot(pix);
    pending_dots.push_back(typed ? want : got);
    if (got.xfer_start) begin
      roll       = $urandom_range(0, 99);
      px_style   = roll < 80 ? PIX_RAMP : (roll < 97 ? PIX_NOISE : PIX_STUCK);
      px_ramp    = 0;
      stuck_left = $urandom_range(300, 1200);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_LYC_VALUE:     cfg_sh.lyc_value     = data;
      REG_STAT_ENABLES:  cfg_sh.stat_enables  = data[2:0];
      REG_WINDOW_ENABLE: cfg_sh.window_enable = data[0];
      REG_WINDOW_Y:      cfg_sh.window_y      = data;
      REG_WINDOW_X:      cfg_sh.window_x      = data;
      default: ;
    endcase
  endtask

  // Settings aimed at the current line so LYC and window edges get hit
  function cfg_t pick_settings(input int ph);
    cfg_t c;
    if (ph == 0) return '0;
    if (ph == 1) return '1;
    case ($urandom_range(0, 5))
      0:       c.lyc_value = st_ly + 8'($urandom_range(0, 12));
      1:       c.lyc_value = LINE_W'(VISIBLE_LINES);
      2:       c.lyc_value = LINE_W'(TOTAL_LINES);    // only seen as LY wraps
      3:       c.lyc_value = '0;
      4:       c.lyc_value = '1;
      default: c.lyc_value = LINE_W'($urandom_range(0, 255));
    endcase
    c.stat_enables  = 3'($urandom_range(0, 7));
    c.window_enable = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 5))
      0:       c.window_y = '0;
      1:       c.window_y = st_ly;
      2:       c.window_y = st_ly + 8'd1;
      3:       c.window_y = LINE_W'(VISIBLE_LINES - 1);
      4:       c.window_y = LINE_W'(VISIBLE_LINES);
      default: c.window_y = LINE_W'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 5))
      0:       c.window_x = '0;
      1:       c.window_x = 8'd7;
      2:       c.window_x = LINE_W'(WIN_X_LIMIT);
      3:       c.window_x = LINE_W'(WIN_X_LIMIT + 1);
      4:       c.window_x = '1;
      default: c.window_x = LINE_W'($urandom_range(0, 255));
    endcase
    // approaching vblank: LYC on the first vblank line with every source on
    if (st_ly >= 112 && st_ly < VISIBLE_LINES) begin
      c.lyc_value    = LINE_W'(VISIBLE_LINES);
      c.stat_enables = 3'b111;
    end
    return c;
  endfunction

  task automatic apply_settings(input cfg_t c);
    in_valid <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk);
    // unused index first; must leave every register alone
    write_reg(REG_WINDOW_X + CFG_IDX_W'($urandom_range(1, 3)),
              CFG_DATA_W'($urandom_range(0, 255)));
    write_reg(REG_LYC_VALUE,     c.lyc_value);
    write_reg(REG_STAT_ENABLES,  CFG_DATA_W'(c.stat_enables));
    write_reg(REG_WINDOW_ENABLE, CFG_DATA_W'(c.window_enable));
    write_reg(REG_WINDOW_Y,      c.window_y);
    write_reg(REG_WINDOW_X,      c.window_x);
    cfg_we <= 1'b0;
  endtask

  initial begin
    dir_row_t row;
    res_t     want;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) begin
      row             = DIRECTED[i];
      want            = '0;
      want.mode       = CODE_OAM;
      want.scan_start = row.scan;
      push_dot(row.pix, row.typed, want);
    end
    for (int ph = 0; ph < N_PHASES; ph++) begin
      apply_settings(pick_settings(ph));
      steady <= (ph == STEADY_PHASE);
      for (int n = 0; n < PHASE_DOTS; n++) begin
        if (ph == HOLD_PHASE && n == 100) hold_req <= hold_req + 1;
        push_dot(next_pixels(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_fields == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Result side: random stalls, a long hold when asked, none while steady
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  function void check_field(input string name, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      bad_fields++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dots.size() == 0) begin
        $error("result beat with nothing expected");
        bad_fields++;
      end else begin
        want = pending_dots.pop_front();
        check_field("mode",         want.mode,         out_mode);
        check_field("line_number",  want.line_number,  out_line_number);
        check_field("coincidence",  want.coincidence,  out_coincidence);
        check_field("window_row",   want.window_row,   out_window_row);
        check_field("stat_irq",     want.stat_irq,     out_stat_irq);
        check_field("vblank_irq",   want.vblank_irq,   out_vblank_irq);
        check_field("scan_start",   want.scan_start,   out_scan_start);
        check_field("xfer_start",   want.xfer_start,   out_xfer_start);
        check_field("xfer_end",     want.xfer_end,     out_xfer_end);
        check_field("frame_number", want.frame_number, out_frame_number);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule
